// ===== hdl/stsc_pkg.sv =====
`timescale 1ns / 1ps

package stsc_pkg;

	localparam int MAX_LEN    = 1024;
	localparam int DATA_WIDTH = 16;

	// entry 0 (the seed, key 0) lives in a register, the rest in memory
	localparam int TBL_DEPTH = MAX_LEN;
	localparam int TBL_AW    = $clog2(TBL_DEPTH);
	localparam int USED_W    = $clog2(TBL_DEPTH + 1);

	localparam int SUM_W   = 32;
	localparam int OCC_W   = 11;
	localparam int COUNT_W = 20;

	localparam logic [OCC_W-1:0] OCC_MAX = {OCC_W{1'b1}};
	localparam logic [USED_W-1:0] USED_FULL = USED_W'(TBL_DEPTH);

	localparam longint TOTAL_BOUND = (longint'(MAX_LEN) * longint'(MAX_LEN + 1)) / 2;
	localparam longint COUNT_MAX   = (longint'(1) << COUNT_W) - 1;
	localparam logic [COUNT_W-1:0] TOTAL_LIMIT =
		(TOTAL_BOUND > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(TOTAL_BOUND);

	typedef struct packed {
		logic signed [15:0] element_value;
		logic               is_last;
	} in_word_t;

	typedef struct packed {
		logic [COUNT_W-1:0] subarray_count;
		logic               last_out;
		logic               table_overflow;
	} out_word_t;

	typedef struct packed {
		logic [SUM_W-1:0] key;
		logic [OCC_W-1:0] occ;
	} entry_t;

	typedef struct packed {
		logic              we;
		logic [TBL_AW-1:0] waddr;
		entry_t            wdata;
		logic [TBL_AW-1:0] raddr;
	} mem_req_t;

	function automatic logic [SUM_W-1:0] elem_extend(input logic [15:0] raw);
		logic [DATA_WIDTH-1:0] low;
		low = raw[DATA_WIDTH-1:0];
		return SUM_W'(signed'(low));
	endfunction

endpackage

// ===== hdl/stsc_mem.sv =====
`timescale 1ns / 1ps

module stsc_mem
	import stsc_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output entry_t   rd_data
);

	entry_t mem_q [TBL_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[req.raddr];
	end

endmodule

// ===== hdl/stsc_ctrl.sv =====
`timescale 1ns / 1ps

module stsc_ctrl
	import stsc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [SUM_W-1:0] target,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_word_t         in_data,
	output logic             res_valid,
	input  logic             res_ready,
	output out_word_t        res_data,
	output mem_req_t         mem_req,
	input  entry_t           mem_rd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]         state_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W-1:0]   want_q;
	logic [COUNT_W-1:0] total_q;
	logic [USED_W-1:0]  used_q;
	logic [OCC_W-1:0]   occ0_q;
	logic               ovf_q;
	logic               last_q;
	logic [USED_W-1:0]  scan_q;
	logic               pend_q;
	logic [TBL_AW-1:0]  pend_idx_q;
	logic               hit_w_q;
	logic [OCC_W-1:0]   cnt_w_q;
	logic               hit_s_q;
	logic               seed_s_q;
	logic [TBL_AW-1:0]  idx_s_q;
	logic [OCC_W-1:0]   cnt_s_q;

	logic               scan_more;
	logic [COUNT_W:0]   total_sum;
	logic [OCC_W-1:0]   cnt_s_inc;
	logic [OCC_W-1:0]   occ0_inc;

	assign scan_more = (scan_q < used_q);
	assign total_sum = {1'b0, total_q} + (COUNT_W + 1)'(cnt_w_q);
	assign cnt_s_inc = (cnt_s_q == OCC_MAX) ? cnt_s_q : cnt_s_q + OCC_W'(1);
	assign occ0_inc  = (occ0_q == OCC_MAX) ? occ0_q : occ0_q + OCC_W'(1);

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res_data  = '{subarray_count: total_q, last_out: last_q, table_overflow: ovf_q};

	always_comb begin
		mem_req.raddr = scan_q[TBL_AW-1:0];
		mem_req.we    = 1'b0;
		mem_req.waddr = used_q[TBL_AW-1:0];
		mem_req.wdata = '{key: sum_q, occ: OCC_W'(1)};
		if (state_q == ST_UPD) begin
			if (hit_s_q) begin
				mem_req.we    = !seed_s_q;
				mem_req.waddr = idx_s_q;
				mem_req.wdata = '{key: sum_q, occ: cnt_s_inc};
			end else begin
				mem_req.we = (used_q < USED_FULL);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q   <= '0;
			total_q <= '0;
			used_q  <= '0;
			occ0_q  <= OCC_W'(1);
			ovf_q   <= 1'b0;
			scan_q  <= '0;
			pend_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sum_q   <= sum_q + elem_extend(in_data.element_value);
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					scan_q  <= '0;
					pend_q  <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					pend_q <= scan_more;
					if (scan_more) begin
						scan_q <= scan_q + USED_W'(1);
					end else if (!pend_q) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (hit_w_q) begin
						total_q <= (total_sum > (COUNT_W + 1)'(TOTAL_LIMIT)) ?
							TOTAL_LIMIT : total_sum[COUNT_W-1:0];
					end
					if (hit_s_q) begin
						if (seed_s_q) begin
							occ0_q <= occ0_inc;
						end
					end else if (used_q < USED_FULL) begin
						used_q <= used_q + USED_W'(1);
					end else begin
						ovf_q <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						// end of sequence: back to the seeded table
						if (last_q) begin
							sum_q   <= '0;
							total_q <= '0;
							used_q  <= '0;
							occ0_q  <= OCC_W'(1);
							ovf_q   <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// lookup payload, only meaningful within one item
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			last_q <= in_data.is_last;
		end
		pend_idx_q <= scan_q[TBL_AW-1:0];
		if (state_q == ST_PREP) begin
			want_q   <= sum_q - target;
			// seed entry holds key 0
			hit_w_q  <= (sum_q == target);
			cnt_w_q  <= occ0_q;
			hit_s_q  <= (sum_q == '0);
			seed_s_q <= 1'b1;
			idx_s_q  <= '0;
			cnt_s_q  <= occ0_q;
		end else if (state_q == ST_SCAN && pend_q) begin
			// stored keys are unique and never 0, so at most one hit each
			if (mem_rd.key == want_q) begin
				hit_w_q <= 1'b1;
				cnt_w_q <= mem_rd.occ;
			end
			if (mem_rd.key == sum_q) begin
				hit_s_q  <= 1'b1;
				seed_s_q <= 1'b0;
				idx_s_q  <= pend_idx_q;
				cnt_s_q  <= mem_rd.occ;
			end
		end
	end

endmodule

// ===== hdl/subarray_target_sum_counter_top.sv =====
`timescale 1ns / 1ps

// Counts contiguous subarrays whose sum equals target_sum over a sequence of
// signed elements, giving the running (saturating) count with every element and
// clearing the sequence state after the element flagged is_last. Prefix sums
// are kept in a 1024-word table plus a seed entry for sum 0, searched by a
// linear scan that reads one table word per cycle. An element's result
// lands in the output register once the controller has passed its prepare,
// scan, update and done states; the scan covers the n distinct non-zero
// prefix sums stored so far in the sequence (0 to 1024). in_ready is low
// from acceptance until the result has moved to the output register, so a
// stalled output holds the input off as well. The table is tracked by a fill
// count, so no clearing pass is needed after reset or at the end of a
// sequence. target_sum may be written at any cycle the block is idle.
module subarray_target_sum_counter_top
	import stsc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_word_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_word_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [SUM_W-1:0] cfg_data
);

	logic [SUM_W-1:0] target_q;
	logic             out_valid_q;
	out_word_t        out_data_q;

	logic             res_valid;
	logic             res_ready;
	out_word_t        res_data;
	mem_req_t         mem_req;
	entry_t           mem_rd;

	assign cfg_ready = 1'b1;
	assign res_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_valid) begin
			target_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res_data;
		end
	end

	stsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.target    (target_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.mem_req   (mem_req),
		.mem_rd    (mem_rd)
	);

	stsc_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (mem_rd)
	);

`ifndef SYNTH
	// an accepted word keeps the block busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while previous word still in work");

	// a result never coincides with a new input word
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_valid && in_ready))
		else $error("result pending while idle");

	// a handed-over result shows on the output next cycle
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> out_valid)
		else $error("result lost at output register");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.subarray_count <= TOTAL_LIMIT))
		else $error("subarray count beyond its saturation bound");
`endif

endmodule
